// File: design/bodd_pkg.sv
// ----------------------------------------------------------------------------
// Byte-offset delta decoder package
// Shared types and constants for the front, queue and back of the decoder.
// ----------------------------------------------------------------------------
package bodd_pkg;

   localparam logic [7:0]  ESCAPE_BYTE  = 8'h80;    // -128 as a byte
   localparam logic [15:0] ESCAPE_SHORT = 16'h8000; // -32768 as a 16-bit word

   // Where the front stands within an escaped delta.
   typedef enum logic [2:0] {
      PH_PLAIN    = 3'd0,
      PH_SHORT_LO = 3'd1,
      PH_SHORT_HI = 3'd2,
      PH_LONG_B0  = 3'd3,
      PH_LONG_B1  = 3'd4,
      PH_LONG_B2  = 3'd5,
      PH_LONG_B3  = 3'd6
   } phase_type;

   // One queued operation for the accumulator.
   typedef struct packed {
      logic [31:0] delta;  // sign-extended delta to add
      logic        emit;   // add the delta and send the new value
      logic        clear;  // zero the accumulator afterwards (end of buffer)
   } qentry_type;

endpackage

// File: design/bodd_front.sv
// ----------------------------------------------------------------------------
// Byte-offset decoder front
// Follows the escape sequence byte by byte and turns completed deltas and
// buffer ends into queue entries.
// ----------------------------------------------------------------------------
module bodd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                last_of_buffer,
   output logic                push,
   output bodd_pkg::qentry_type push_entry
);

   bodd_pkg::phase_type phase_ff, phase_in;
   logic [23:0]         partial_ff, partial_in;
   logic                emit;
   logic [31:0]         delta;
   logic [15:0]         short_word;

   assign short_word = {data_byte, partial_ff[7:0]};

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            bodd_pkg::PH_PLAIN:
               phase_in = (data_byte == bodd_pkg::ESCAPE_BYTE) ?
                          bodd_pkg::PH_SHORT_LO : bodd_pkg::PH_PLAIN;
            bodd_pkg::PH_SHORT_LO: phase_in = bodd_pkg::PH_SHORT_HI;
            bodd_pkg::PH_SHORT_HI:
               phase_in = (short_word == bodd_pkg::ESCAPE_SHORT) ?
                          bodd_pkg::PH_LONG_B0 : bodd_pkg::PH_PLAIN;
            bodd_pkg::PH_LONG_B0: phase_in = bodd_pkg::PH_LONG_B1;
            bodd_pkg::PH_LONG_B1: phase_in = bodd_pkg::PH_LONG_B2;
            bodd_pkg::PH_LONG_B2: phase_in = bodd_pkg::PH_LONG_B3;
            default:              phase_in = bodd_pkg::PH_PLAIN;
         endcase
         if (last_of_buffer) begin
            phase_in = bodd_pkg::PH_PLAIN;
         end
      end
   end

   // Delta assembly and queue entry.
   always_comb begin
      emit       = 1'b0;
      delta      = '0;
      partial_in = partial_ff;
      case (phase_ff)
         bodd_pkg::PH_SHORT_LO: partial_in = {16'd0, data_byte};
         bodd_pkg::PH_SHORT_HI: begin
            partial_in = '0;
            if (short_word != bodd_pkg::ESCAPE_SHORT) begin
               emit  = 1'b1;
               delta = {{16{short_word[15]}}, short_word};
            end
         end
         bodd_pkg::PH_LONG_B0: partial_in[7:0]   = data_byte;
         bodd_pkg::PH_LONG_B1: partial_in[15:8]  = data_byte;
         bodd_pkg::PH_LONG_B2: partial_in[23:16] = data_byte;
         bodd_pkg::PH_LONG_B3: begin
            emit       = 1'b1;
            delta      = {data_byte, partial_ff};
            partial_in = '0;
         end
         default: begin
            partial_in = '0;
            if (data_byte != bodd_pkg::ESCAPE_BYTE) begin
               emit  = 1'b1;
               delta = {{24{data_byte[7]}}, data_byte};
            end
         end
      endcase
      if (last_of_buffer) begin
         partial_in = '0;
      end
      push             = accept && (emit || last_of_buffer);
      push_entry.delta = delta;
      push_entry.emit  = emit;
      push_entry.clear = last_of_buffer;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= bodd_pkg::PH_PLAIN;
         partial_ff <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         partial_ff <= partial_in;
      end
   end

endmodule

// File: design/bodd_queue.sv
// ----------------------------------------------------------------------------
// Byte-offset decoder queue
// Short first-in first-out queue of accumulator operations between front
// and back.
// ----------------------------------------------------------------------------
module bodd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bodd_pkg::qentry_type push_entry,
   input  logic                 pop,
   output bodd_pkg::qentry_type head_entry,
   output logic                 empty,
   output logic                 full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bodd_pkg::qentry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff,  count_in;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

// File: design/bodd_back.sv
// ----------------------------------------------------------------------------
// Byte-offset decoder back
// Applies queued deltas to the running value and holds the result word in
// an output register.
// ----------------------------------------------------------------------------
module bodd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  bodd_pkg::qentry_type head_entry,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata
);

   logic [31:0] acc_ff, acc_in;
   logic [31:0] sum;
   logic        valid_ff, valid_in;
   logic [31:0] data_ff;

   assign sum = acc_ff + head_entry.delta;

   // A clear-only entry never needs the output register.
   assign pop = !empty && (!head_entry.emit || !valid_ff || rsp_tready);

   always_comb begin
      acc_in   = acc_ff;
      valid_in = valid_ff && !rsp_tready;
      if (pop) begin
         if (head_entry.emit) begin
            acc_in   = sum;
            valid_in = 1'b1;
         end
         if (head_entry.clear) begin
            acc_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_entry.emit) begin
         data_ff <= sum;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   a_clear_zeroes_acc: assert property (@(posedge clock) disable iff (reset)
      pop && head_entry.clear |=> acc_ff == '0)
      else $error("accumulator not cleared at end of buffer");

   a_emit_loads_output: assert property (@(posedge clock) disable iff (reset)
      pop && head_entry.emit |=> valid_ff && (data_ff == acc_ff || $past(head_entry.clear)))
      else $error("emitted value does not match accumulator");

endmodule

// File: design/byte_offset_delta_decoder_unit.sv
// ----------------------------------------------------------------------------
// Byte-offset delta decoder unit
// Decodes a byte-offset compressed stream into 32-bit pixel values.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel takes one compressed byte per word in req_tdata, with
//   req_tlast marking the final byte of a buffer. The rsp_ channel gives one
//   signed 32-bit pixel value per word whenever a delta is completed; escape
//   bytes and the leading bytes of escaped deltas produce no word.
//   When an accepted byte completes a delta, the front writes its entry into
//   the queue at the accepting edge; the back then adds the delta and loads
//   the output register once that register is free, raising rsp_tvalid.
//   One byte is accepted every cycle while the queue is not full; the rate
//   is set by the single 32-bit add in the back and the one-byte-per-cycle
//   phase tracker in the front.
//   The queue lets the front keep taking bytes while the receiver stalls;
//   req_tready falls only once QUEUE_DEPTH operations are waiting.
//   Synchronous reset returns the escape phase, the running value and the
//   queue to empty; the first byte may follow at once. After the byte
//   marked last, the running value and phase return to zero and any
//   partially received escaped delta is dropped.
// ----------------------------------------------------------------------------
module byte_offset_delta_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] pixel_value
);

   logic                 accept;
   logic                 push;
   logic                 pop;
   logic                 q_empty;
   logic                 q_full;
   bodd_pkg::qentry_type push_entry;
   bodd_pkg::qentry_type head_entry;

   // Front accepts whenever the queue has room, whether or not this byte
   // will need an entry.
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   bodd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_tdata),
      .last_of_buffer (req_tlast),
      .push           (push),
      .push_entry     (push_entry)
   );

   bodd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (q_empty),
      .full       (q_full)
   );

   // Back drains the queue and owns the output register.
   bodd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .empty      (q_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-offset delta decoder unit testbench
// Sends compressed byte streams through the decoder and checks every pixel
// value that comes back against a decoder modelled inside the bench. Short
// directed buffers cover the extremes and the escape cases. Random buffers of
// well-formed deltas follow, with some truncated escapes and raw noise among
// them. Both sides idle at random, with one long receiver stall.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 950;
   localparam int HOLD_START   = 300;   // cycle at which the long receiver stall begins
   localparam int HOLD_LENGTH  = 250;
   localparam int STEADY_FIRST = 700;   // window in which neither side idles
   localparam int STEADY_LAST  = 1000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } comp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   comp_word_type pending_words[$];
   comp_word_type next_word;
   logic [31:0] pixel_expect_q[$];
   logic [31:0] pixel_want;
   logic        req_taken = 1'b0;
   int          hold_left = 0;
   int          cycle_count = 0;
   int          error_count = 0;
   int          words_sent = 0;
   int          buffers_ended = 0;
   int          pixels_checked = 0;
   int          short_escapes = 0;
   int          long_escapes = 0;

   // Decoder state as the bench sees it.
   bodd_pkg::phase_type dec_phase = bodd_pkg::PH_PLAIN;
   logic [31:0] dec_running = '0;
   logic [31:0] dec_partial = '0;

   wire steady_window = cycle_count >= STEADY_FIRST && cycle_count < STEADY_LAST;

   byte_offset_delta_decoder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Advances the decoder by one compressed byte and queues the pixel value
   // it completes, if any.
   task automatic decode_compressed_byte(input logic [7:0] b, input logic last);
      logic        emit;
      logic [31:0] delta;
      emit  = 1'b0;
      delta = '0;
      case (dec_phase)
         bodd_pkg::PH_SHORT_LO: begin
            dec_partial = {24'd0, b};
            dec_phase   = bodd_pkg::PH_SHORT_HI;
         end
         bodd_pkg::PH_SHORT_HI: begin
            dec_partial = {16'd0, b, dec_partial[7:0]};
            if (dec_partial[15:0] == bodd_pkg::ESCAPE_SHORT) begin
               dec_partial = '0;
               dec_phase   = bodd_pkg::PH_LONG_B0;
            end else begin
               delta     = {{16{dec_partial[15]}}, dec_partial[15:0]};
               emit      = 1'b1;
               dec_phase = bodd_pkg::PH_PLAIN;
               short_escapes++;
            end
         end
         bodd_pkg::PH_LONG_B0, bodd_pkg::PH_LONG_B1, bodd_pkg::PH_LONG_B2: begin
            dec_partial = dec_partial
               | ({24'd0, b} << (8 * (int'(dec_phase) - int'(bodd_pkg::PH_LONG_B0))));
            dec_phase   = bodd_pkg::phase_type'(int'(dec_phase) + 1);
         end
         bodd_pkg::PH_LONG_B3: begin
            delta     = {b, dec_partial[23:0]};
            emit      = 1'b1;
            dec_phase = bodd_pkg::PH_PLAIN;
            long_escapes++;
         end
         default: begin
            if (b == bodd_pkg::ESCAPE_BYTE) begin
               dec_partial = '0;
               dec_phase   = bodd_pkg::PH_SHORT_LO;
            end else begin
               delta     = {{24{b[7]}}, b};
               emit      = 1'b1;
               dec_phase = bodd_pkg::PH_PLAIN;
            end
         end
      endcase
      if (emit) begin
         dec_running = dec_running + delta;
         dec_partial = '0;
         pixel_expect_q.push_back(dec_running);
      end
      if (last) begin
         dec_phase   = bodd_pkg::PH_PLAIN;
         dec_running = '0;
         dec_partial = '0;
      end
   endtask

   task automatic add_word(input logic [7:0] b, input logic last);
      pending_words.push_back('{data: b, last: last});
   endtask

   // One buffer: mostly well-formed deltas of every width, sometimes cut off
   // within an escape, sometimes raw noise.
   task automatic add_random_buffer();
      logic [7:0]  bytes_q[$];
      logic [7:0]  plain;
      logic [15:0] short_delta;
      logic [31:0] long_delta;
      int          kind;
      int          cut;
      if ($urandom_range(11) == 0) begin
         repeat ($urandom_range(10, 1)) bytes_q.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(24, 1)) begin
            kind = $urandom_range(9);
            if (kind < 6) begin
               do plain = 8'($urandom); while (plain == bodd_pkg::ESCAPE_BYTE);
               bytes_q.push_back(plain);
            end else if (kind < 8) begin
               do short_delta = 16'($urandom);
               while (short_delta == bodd_pkg::ESCAPE_SHORT);
               bytes_q.push_back(bodd_pkg::ESCAPE_BYTE);
               bytes_q.push_back(short_delta[7:0]);
               bytes_q.push_back(short_delta[15:8]);
            end else begin
               long_delta = $urandom;
               bytes_q.push_back(bodd_pkg::ESCAPE_BYTE);
               bytes_q.push_back(bodd_pkg::ESCAPE_SHORT[7:0]);
               bytes_q.push_back(bodd_pkg::ESCAPE_SHORT[15:8]);
               for (int i = 0; i < 4; i++) bytes_q.push_back(long_delta[8*i +: 8]);
            end
         end
         // The buffer may end partway through an escaped delta.
         if ($urandom_range(7) == 0) begin
            cut = $urandom_range(6, 1);
            bytes_q.push_back(bodd_pkg::ESCAPE_BYTE);
            if (cut == 2) bytes_q.push_back(8'($urandom));
            if (cut >= 3) begin
               bytes_q.push_back(bodd_pkg::ESCAPE_SHORT[7:0]);
               bytes_q.push_back(bodd_pkg::ESCAPE_SHORT[15:8]);
               repeat (cut - 3) bytes_q.push_back(8'($urandom));
            end
         end
      end
      foreach (bytes_q[i]) add_word(bytes_q[i], i == bytes_q.size() - 1);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // Prediction on accepted bytes, then the check of returned pixel values.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            words_sent++;
            if (req_tlast) buffers_ended++;
            decode_compressed_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_expect_q.size() == 0) begin
               report_mismatch($sformatf("pixel value %h with nothing expected", rsp_tdata));
            end else begin
               pixel_want = pixel_expect_q.pop_front();
               pixels_checked++;
               if (rsp_tdata !== pixel_want)
                  report_mismatch($sformatf("pixel value %h, expected %h",
                                            rsp_tdata, pixel_want));
            end
         end
      end
   end

   // Sender: a word once offered stays on the bus until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_words.size() != 0 && (steady_window || $urandom_range(99) >= 35)) begin
            next_word = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_word.data;
            req_tlast  <= next_word.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver, with one long stall so that the decoder's queue fills up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (cycle_count == HOLD_START) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_LENGTH;
      end else begin
         rsp_tready <= steady_window || ($urandom_range(99) >= 35);
      end
   end

   initial begin
      // Plain deltas at the extremes: 0, +127, -127, -1.
      add_word(8'h00, 1'b0); add_word(8'h7F, 1'b0); add_word(8'h81, 1'b0);
      add_word(8'hFF, 1'b0);
      // Short escapes: +32767 and -32767.
      add_word(bodd_pkg::ESCAPE_BYTE, 1'b0); add_word(8'hFF, 1'b0); add_word(8'h7F, 1'b0);
      add_word(bodd_pkg::ESCAPE_BYTE, 1'b0); add_word(8'h01, 1'b0); add_word(8'h80, 1'b0);
      // Long escape of +2^31-1.
      add_word(bodd_pkg::ESCAPE_BYTE, 1'b0); add_word(8'h00, 1'b0); add_word(8'h80, 1'b0);
      add_word(8'hFF, 1'b0); add_word(8'hFF, 1'b0); add_word(8'hFF, 1'b0);
      add_word(8'h7F, 1'b0);
      // Long escape of -2^31, completed on the last byte of the buffer.
      add_word(bodd_pkg::ESCAPE_BYTE, 1'b0); add_word(8'h00, 1'b0); add_word(8'h80, 1'b0);
      add_word(8'h00, 1'b0); add_word(8'h00, 1'b0); add_word(8'h00, 1'b0);
      add_word(8'h80, 1'b1);
      // Buffer that ends within a short escape, then a plain last byte.
      add_word(bodd_pkg::ESCAPE_BYTE, 1'b0); add_word(8'h34, 1'b1);
      add_word(8'h05, 1'b1);

      while (pending_words.size() < RANDOM_WORDS + 27) add_random_buffer();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_words.size() != 0 || req_tvalid || pixel_expect_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (pixel_expect_q.size() != 0)
         report_mismatch($sformatf("%0d pixel values never arrived", pixel_expect_q.size()));

      $display("Run covered %0d compressed words in %0d buffers, %0d pixel values checked.",
               words_sent, buffers_ended, pixels_checked);
      $display("Decoded %0d short and %0d long escaped deltas; %0d mismatches.",
               short_escapes, long_escapes, error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: byte_offset_delta_decoder_unit.f
design/bodd_pkg.sv
design/bodd_front.sv
design/bodd_queue.sv
design/bodd_back.sv
design/byte_offset_delta_decoder_unit.sv
tb/tb.sv
